/* hdl/node_id_registry_allocator_macros.svh */
// Assertion macros shared by the node ID registry allocator RTL.
`ifndef NODE_ID_REGISTRY_ALLOCATOR_MACROS_SVH
`define NODE_ID_REGISTRY_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define NIDR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nidr: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define NIDR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nidr: next-cycle check failed");

`else

`define NIDR_ASSERT_IMP(label, ante, cons)
`define NIDR_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* hdl/nidr_pkg.sv */
// Types and constants of the node ID registry allocator.
`timescale 1ns / 1ps
`default_nettype none

package nidr_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int SLOT_W      = 5;
  localparam int CNT_W       = 6;
  localparam int ID_W        = 8;
  localparam int UID_W       = 32;
  localparam int TICK_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  // register index, taken from paddr[2]
  localparam logic REG_FIRST_ID   = 1'b0;
  localparam logic REG_UNASSIGNED = 1'b1;

  localparam logic [ID_W-1:0] FIRST_ID_RST   = 8'd1;
  localparam logic [ID_W-1:0] UNASSIGNED_RST = 8'd255;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2
  } nidr_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } nidr_state_e;

endpackage

`default_nettype wire

/* hdl/node_id_registry_allocator.sv */
// Node ID registry allocator: UID lookup and ID assignment over an entry memory.
// Start is taken only while idle; the scan reads one slot per cycle into a read
// register and compares it with the latched UID. A match gives a hit; a scan of
// every filled slot with no match gives a new ID, or full. One word at a time.
// Results cannot be stalled. Reset clears the entry count, loads the next ID from
// the first-ID register default; memory contents are left as is.
`timescale 1ns / 1ps
`default_nettype none

`include "node_id_registry_allocator_macros.svh"

module node_id_registry_allocator
  import nidr_pkg::*;
#(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request word
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [UID_W-1:0]    uid_i,
  input  wire logic [TICK_W-1:0]   now_tick_i,
  // result word, valid for one cycle with done_o
  output logic                     done_o,
  output logic [ID_W-1:0]          node_id_o,
  output logic [1:0]               status_o,
  output logic [SLOT_W-1:0]        slot_o,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  // Usable capacity: never more than the memory depth.
  localparam logic [CNT_W-1:0] CAP =
    CNT_W'((MAX_ENTRIES > STORE_DEPTH) ? STORE_DEPTH : MAX_ENTRIES);

  localparam int ENT_W = ID_W + UID_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ID_W-1:0] first_id_q, first_id_d;
  logic [ID_W-1:0] unassigned_q, unassigned_d;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    first_id_d   = first_id_q;
    unassigned_d = unassigned_q;
    if (cfg_wr) begin
      case (paddr[2])
        REG_FIRST_ID:   first_id_d   = pwdata[ID_W-1:0];
        REG_UNASSIGNED: unassigned_d = pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FIRST_ID:   prdata = {{(DATA_W-ID_W){1'b0}}, first_id_q};
      REG_UNASSIGNED: prdata = {{(DATA_W-ID_W){1'b0}}, unassigned_q};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  nidr_state_e       state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;      // filled entries
  logic [ID_W-1:0]   next_id_q, next_id_d;
  logic [CNT_W-1:0]  idx_q, idx_d;          // next slot to read
  logic              cmp_vld_q, cmp_vld_d;  // read data is valid this cycle
  logic [SLOT_W-1:0] cmp_slot_q, cmp_slot_d;

  // latched request word
  logic [UID_W-1:0]  uid_q;
  logic [TICK_W-1:0] tick_q;

  // result register
  logic              done_q, done_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  nidr_status_e      res_st_q, res_st_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;

  // memories: entry = {node id, uid}; last-seen ticks kept apart
  logic [ENT_W-1:0]  ent_mem  [STORE_DEPTH];
  logic [TICK_W-1:0] seen_mem [STORE_DEPTH];
  logic [ENT_W-1:0]  rd_q;

  logic accept, in_range, issue, hit, miss, full, alloc;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start & ~busy;
  assign in_range = (idx_q < count_q);
  assign issue    = (state_q == S_SCAN) & in_range;
  assign hit      = (state_q == S_SCAN) & cmp_vld_q & (rd_q[UID_W-1:0] == uid_q);
  // scan is over once every filled slot has been compared without a match
  assign miss     = (state_q == S_SCAN) & ~hit & ~in_range;
  assign full     = (count_q >= CAP) | (next_id_q == unassigned_q);
  assign alloc    = miss & ~full;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_SCAN;
      S_SCAN: if (hit | miss) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    idx_d      = idx_q;
    cmp_vld_d  = issue;
    cmp_slot_d = idx_q[SLOT_W-1:0];
    count_d    = count_q;
    next_id_d  = next_id_q;
    done_d     = 1'b0;
    res_id_d   = res_id_q;
    res_st_d   = res_st_q;
    res_slot_d = res_slot_q;

    if (accept) begin
      idx_d = '0;
    end else if (issue) begin
      idx_d = idx_q + 1'b1;
    end

    if (hit) begin
      done_d     = 1'b1;
      res_id_d   = rd_q[ENT_W-1:UID_W];
      res_st_d   = ST_HIT;
      res_slot_d = cmp_slot_q;
    end else if (alloc) begin
      done_d     = 1'b1;
      res_id_d   = next_id_q;
      res_st_d   = ST_NEW;
      res_slot_d = count_q[SLOT_W-1:0];
      count_d    = count_q + 1'b1;
      next_id_d  = next_id_q + 1'b1;
    end else if (miss) begin
      done_d     = 1'b1;
      res_id_d   = unassigned_q;
      res_st_d   = ST_FULL;
      res_slot_d = '0;
    end

    // first-ID write reloads the counter only on an empty registry
    if (cfg_wr && (paddr[2] == REG_FIRST_ID) && (count_q == '0)) begin
      next_id_d = pwdata[ID_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      next_id_q    <= FIRST_ID_RST;
      first_id_q   <= FIRST_ID_RST;
      unassigned_q <= UNASSIGNED_RST;
      idx_q        <= '0;
      cmp_vld_q    <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      next_id_q    <= next_id_d;
      first_id_q   <= first_id_d;
      unassigned_q <= unassigned_d;
      idx_q        <= idx_d;
      cmp_vld_q    <= cmp_vld_d;
      done_q       <= done_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cmp_slot_q <= cmp_slot_d;
    res_id_q   <= res_id_d;
    res_st_q   <= res_st_d;
    res_slot_q <= res_slot_d;
    if (accept) begin
      uid_q  <= uid_i;
      tick_q <= now_tick_i;
    end
  end

  // entry memory: one read port for the scan, one write port for appends
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= ent_mem[idx_q[SLOT_W-1:0]];
    end
    if (alloc) begin
      ent_mem[count_q[SLOT_W-1:0]] <= {next_id_q, uid_q};
    end
  end

  // last-seen memory: written on append and refreshed on hit
  always_ff @(posedge clk_i) begin
    if (hit) begin
      seen_mem[cmp_slot_q] <= tick_q;
    end else if (alloc) begin
      seen_mem[count_q[SLOT_W-1:0]] <= tick_q;
    end
  end

  assign done_o    = done_q;
  assign node_id_o = res_id_q;
  assign status_o  = res_st_q;
  assign slot_o    = res_slot_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `NIDR_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CAP)
  `NIDR_ASSERT_IMP(a_done_idle, done_o, !busy)
  `NIDR_ASSERT_NXT(a_accept_busy, accept, busy)
  `NIDR_ASSERT_IMP(a_scan_bound, busy, idx_q <= count_q)
  `NIDR_ASSERT_NXT(a_new_counts, alloc, count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire
